[sv/tbkt_pkg.sv]
package tbkt_pkg;

	localparam int unsigned MS_PER_SECOND = 1000;

	// Exact unsigned 32-bit division by MS_PER_SECOND as a reciprocal multiply
	localparam int unsigned DIV_L     = $clog2(MS_PER_SECOND);
	localparam int unsigned DIV_SHIFT = 32 + DIV_L;
	localparam logic [64:0] DIV_NUM   = (65'd1 << DIV_SHIFT) + 65'(MS_PER_SECOND) - 65'd1;
	localparam logic [32:0] DIV_MULT  = 33'(DIV_NUM / 65'(MS_PER_SECOND));

	localparam logic [2:0] MODE_IDLE      = 3'd0;
	localparam logic [2:0] MODE_SET       = 3'd1;
	localparam logic [2:0] MODE_COUNTDOWN = 3'd2;
	localparam logic [2:0] MODE_COUNTUP   = 3'd3;
	localparam logic [2:0] MODE_PAUSED    = 3'd4;
	localparam logic [2:0] MODE_ALARM     = 3'd5;

	localparam logic CFG_STEP  = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	localparam logic [11:0] STEP_RESET  = 12'd60;
	localparam logic [15:0] LIMIT_RESET = 16'd6000;

	typedef struct packed {
		logic [11:0] step;
		logic [15:0] limit;
	} cfg_t;

endpackage

[sv/tbkt_div_ms.sv]
module tbkt_div_ms
	import tbkt_pkg::*;
(
	input  logic [31:0] diff,
	output logic [31:0] quot
);

	logic [64:0] prod;

	assign prod = {33'd0, diff} * {32'd0, DIV_MULT};
	assign quot = 32'(prod >> DIV_SHIFT);

endmodule

[sv/tbkt_ctrl.sv]
module tbkt_ctrl
	import tbkt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        step_en,
	input  logic        lvl_set,
	input  logic        lvl_start,
	input  logic [31:0] now,
	output logic [15:0] shown,
	output logic [2:0]  mode
);

	logic [2:0]  mode_q, mode_d;
	logic [15:0] set_q, set_p, set_d;
	logic [15:0] shown_q, shown_d;
	logic [31:0] start_q, start_d;
	logic        prev_set_q, prev_start_q;

	logic        can_set, push_set, push_start, clear;
	logic [16:0] set_sum;
	logic [31:0] diff, elapsed;
	logic        elapsed_big, cd_done;
	logic [15:0] cd_left, up_val;
	logic [16:0] up_sum;

	assign diff = now - start_q;

	tbkt_div_ms u_div (
		.diff (diff),
		.quot (elapsed)
	);

	always_comb begin
		can_set    = (mode_q == MODE_IDLE) || (mode_q == MODE_SET) || (mode_q == MODE_PAUSED);
		push_set   = can_set && lvl_set && !prev_set_q;
		push_start = lvl_start && !prev_start_q;

		set_sum = {1'b0, shown_q} + {5'd0, cfg.step};
		if (!push_set) begin
			set_p = set_q;
		end else if (set_q >= cfg.limit) begin
			set_p = '0;
		end else begin
			set_p = set_sum[16] ? 16'hFFFF : set_sum[15:0];
		end
		start_d = (push_start && can_set) ? now : start_q;

		elapsed_big = |elapsed[31:16];
		cd_done     = elapsed_big || (elapsed[15:0] >= set_p);
		cd_left     = set_p - elapsed[15:0];
		up_sum      = {1'b0, set_p} + {1'b0, elapsed[15:0]};
		up_val      = (elapsed_big || up_sum[16]) ? 16'hFFFF : up_sum[15:0];

		set_d   = set_p;
		shown_d = shown_q;
		mode_d  = mode_q;
		clear   = lvl_set && lvl_start;

		if (!clear) begin
			case (mode_q)
				MODE_IDLE: begin
					if (push_set) begin
						mode_d = MODE_SET;
					end else if (push_start) begin
						mode_d = MODE_COUNTUP;
					end
				end
				MODE_SET: begin
					shown_d = set_p;
					if (!push_set && push_start) begin
						mode_d = MODE_COUNTDOWN;
					end
				end
				MODE_COUNTDOWN: begin
					shown_d = cd_done ? 16'd0 : cd_left;
					if (push_start) begin
						mode_d = MODE_SET;
						set_d  = cd_done ? 16'd0 : cd_left;
					end else if (cd_done) begin
						mode_d = MODE_ALARM;
					end
				end
				MODE_COUNTUP: begin
					shown_d = up_val;
					if (push_start) begin
						set_d  = up_val;
						mode_d = MODE_PAUSED;
					end
				end
				MODE_PAUSED: begin
					shown_d = set_p;
					if (push_set) begin
						mode_d = MODE_SET;
					end else if (push_start) begin
						mode_d = MODE_COUNTUP;
					end
				end
				MODE_ALARM: begin
					shown_d = '0;
					clear   = push_start;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			set_q        <= '0;
			shown_q      <= '0;
			start_q      <= '0;
			prev_set_q   <= 1'b0;
			prev_start_q <= 1'b0;
		end else if (step_en) begin
			if (clear) begin
				mode_q       <= MODE_IDLE;
				set_q        <= '0;
				shown_q      <= '0;
				start_q      <= '0;
				prev_set_q   <= 1'b0;
				prev_start_q <= 1'b0;
			end else begin
				mode_q       <= mode_d;
				set_q        <= set_d;
				shown_q      <= shown_d;
				start_q      <= start_d;
				prev_set_q   <= lvl_set;
				prev_start_q <= lvl_start;
			end
		end
	end

	assign shown = shown_q;
	assign mode  = mode_q;

endmodule

[sv/two_button_kitchen_timer_core.sv]
// Kitchen timer core: takes one poll word (two button levels and a free-running millisecond
// time) per clock while in_stall is low, and returns one result word per poll, in order. A
// poll is captured in an input register; once the result register is free or draining, the
// timer state is updated and the result becomes valid, and a new poll can be taken every
// cycle while results keep draining. The cycle is set by the path from the input register
// through the 32-bit elapsed-time subtract, the reciprocal multiply that divides by the
// millisecond rate, and the countdown compare into the state registers. Write the step and
// limit registers only while the timer is idle between polls.
module two_button_kitchen_timer_core
	import tbkt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        button_set,
	input  logic        button_start,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] display_seconds,
	output logic [2:0]  timer_mode,
	output logic        alarm_on
);

	cfg_t        cfg_q;
	logic        valid_s1, set_s1, start_s1;
	logic [31:0] now_s1;
	logic        out_valid_q;
	logic        in_take, step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step  <= STEP_RESET;
			cfg_q.limit <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEP:  cfg_q.step  <= cfg_data[11:0];
				CFG_LIMIT: cfg_q.limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// advance the held poll whenever the result register is free or being drained
	assign step_en  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step_en;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= in_take || (valid_s1 && !step_en);
			out_valid_q <= step_en || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			set_s1   <= button_set;
			start_s1 <= button_start;
			now_s1   <= now_ms;
		end
	end

	// the timer state registers double as the result word
	tbkt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.step_en   (step_en),
		.lvl_set   (set_s1),
		.lvl_start (start_s1),
		.now       (now_s1),
		.shown     (display_seconds),
		.mode      (timer_mode)
	);

	assign alarm_on  = (timer_mode == MODE_ALARM);
	assign out_valid = out_valid_q;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with no word held");

	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> out_valid)
		else $error("poll processed but no result word valid");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> ($stable(display_seconds) && $stable(timer_mode)))
		else $error("timer state moved without a poll");

	a_alarm_shows_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(timer_mode == MODE_ALARM) |-> (display_seconds == 16'd0))
		else $error("alarm with nonzero display");

endmodule

[bench/kitchen_timer_checker.sv]
`timescale 1ns / 1ps
module kitchen_timer_checker
	import tbkt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        button_set,
	input  logic        button_start,
	input  logic [31:0] now_ms,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] display_seconds,
	input  logic [2:0]  timer_mode,
	input  logic        alarm_on,
	output int          failures,
	output int          awaiting,
	output int          polls_taken,
	output logic [7:0]  modes_seen
);

	typedef struct packed {
		logic [15:0] secs;
		logic [2:0]  mode;
		logic        alarm;
	} readout_t;

	readout_t    due_readouts[$];
	logic [11:0] step_q;
	logic [15:0] limit_q;
	logic [2:0]  mode_q;
	logic [15:0] set_q;
	logic [15:0] shown_q;
	logic [31:0] start_q;
	logic        prev_set_q;
	logic        prev_start_q;

	task automatic clear_timer();
		mode_q       = MODE_IDLE;
		set_q        = '0;
		shown_q      = '0;
		start_q      = '0;
		prev_set_q   = 1'b0;
		prev_start_q = 1'b0;
	endtask

	// advance the timer by one poll and return what the display should show afterwards
	task automatic tick_timer(input logic lv_set, input logic lv_start, input logic [31:0] now,
			output readout_t word);
		logic [2:0]  mode;
		logic        can_set;
		logic        push_set;
		logic        push_start;
		logic        wipe;
		logic [16:0] loaded;
		logic [31:0] elapsed;
		logic [32:0] up_total;
		mode       = mode_q;
		can_set    = (mode == MODE_IDLE) || (mode == MODE_SET) || (mode == MODE_PAUSED);
		push_set   = can_set && lv_set && !prev_set_q;
		push_start = lv_start && !prev_start_q;
		wipe       = 1'b0;
		if (push_set) begin
			// the new set time builds on what is shown, not on the old set time
			loaded = {1'b0, shown_q} + {5'd0, step_q};
			if (set_q >= limit_q)
				set_q = '0;
			else
				set_q = loaded[16] ? 16'hFFFF : loaded[15:0];
		end
		if (push_start && can_set)
			start_q = now;
		prev_set_q   = lv_set;
		prev_start_q = lv_start;
		elapsed = (now - start_q) / 32'(MS_PER_SECOND);
		if (lv_set && lv_start) begin
			wipe = 1'b1;
		end else begin
			case (mode)
				MODE_IDLE: begin
					if (push_set)
						mode_q = MODE_SET;
					else if (push_start)
						mode_q = MODE_COUNTUP;
				end
				MODE_SET: begin
					shown_q = set_q;
					if (!push_set && push_start)
						mode_q = MODE_COUNTDOWN;
				end
				MODE_COUNTDOWN: begin
					shown_q = (elapsed >= {16'd0, set_q}) ? 16'd0 : set_q - elapsed[15:0];
					if (push_start) begin
						mode_q = MODE_SET;
						set_q  = shown_q;
					end else if (shown_q == 16'd0) begin
						mode_q = MODE_ALARM;
					end
				end
				MODE_COUNTUP: begin
					up_total = {17'd0, set_q} + {1'b0, elapsed};
					shown_q  = (up_total > 33'h0FFFF) ? 16'hFFFF : up_total[15:0];
					if (push_start) begin
						set_q  = shown_q;
						mode_q = MODE_PAUSED;
					end
				end
				MODE_PAUSED: begin
					shown_q = set_q;
					if (push_set)
						mode_q = MODE_SET;
					else if (push_start)
						mode_q = MODE_COUNTUP;
				end
				MODE_ALARM: begin
					shown_q = '0;
					if (push_start)
						wipe = 1'b1;
				end
				default: ;
			endcase
		end
		if (wipe)
			clear_timer();
		word.secs  = shown_q;
		word.mode  = mode_q;
		word.alarm = (mode_q == MODE_ALARM);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		readout_t word;
		if (!arst_n) begin
			clear_timer();
			step_q  = STEP_RESET;
			limit_q = LIMIT_RESET;
			due_readouts.delete();
			failures    = 0;
			polls_taken = 0;
			modes_seen  = '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_STEP)
					step_q = cfg_data[11:0];
				else
					limit_q = cfg_data;
			end
			if (in_valid && !in_stall) begin
				tick_timer(button_set, button_start, now_ms, word);
				due_readouts.push_back(word);
				polls_taken++;
			end
			if (out_valid && !out_stall) begin
				modes_seen[timer_mode] = 1'b1;
				if (due_readouts.size() == 0) begin
					$error("result word with none pending: display_seconds %0d timer_mode %0d",
						display_seconds, timer_mode);
					failures++;
				end else begin
					word = due_readouts.pop_front();
					if (display_seconds !== word.secs) begin
						$error("display_seconds: expected %0d, got %0d", word.secs,
							display_seconds);
						failures++;
					end
					if (timer_mode !== word.mode) begin
						$error("timer_mode: expected %0d, got %0d", word.mode, timer_mode);
						failures++;
					end
					if (alarm_on !== word.alarm) begin
						$error("alarm_on: expected %0d, got %0d", word.alarm, alarm_on);
						failures++;
					end
				end
			end
		end
		awaiting = due_readouts.size();
	end

endmodule

[bench/two_button_kitchen_timer_core_test.sv]
`timescale 1ns / 1ps
module two_button_kitchen_timer_core_test
	import tbkt_pkg::*;
();

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_POLLS = 70;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        button_set;
	logic        button_start;
	logic [31:0] now_ms;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] display_seconds;
	logic [2:0]  timer_mode;
	logic        alarm_on;

	int          failures;
	int          awaiting;
	int          polls_taken;
	logic [7:0]  modes_seen;

	int          send_gap_pct;
	int          recv_gap_pct;
	int          quiet_cycles = 0;
	logic        hold_req;
	logic [31:0] wall_ms;
	int unsigned cur_step;
	int          settings_done;

	two_button_kitchen_timer_core dut (.*);

	kitchen_timer_checker timer_watch (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic offer_poll(input logic lv_set, input logic lv_start, input logic [31:0] t);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		button_set   <= lv_set;
		button_start <= lv_start;
		now_ms       <= t;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic step_ms(input logic lv_set, input logic lv_start, input int unsigned dt);
		wall_ms = wall_ms + dt;
		offer_poll(lv_set, lv_start, wall_ms);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (awaiting != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(input int unsigned step, input int unsigned limit);
		drain();
		write_reg(CFG_STEP, 16'(step));
		write_reg(CFG_LIMIT, 16'(limit));
		cur_step = step;
		settings_done++;
	endtask

	task automatic random_scenario();
		int          kind;
		int unsigned span;
		kind = $urandom_range(0, 99);
		span = ((cur_step == 0) ? 1 : cur_step) * 400;
		if (kind < 40) begin
			// load a few steps, then run down, maybe pausing on the way
			repeat ($urandom_range(1, 4)) begin
				step_ms(1'b1, 1'b0, $urandom_range(0, 500));
				step_ms(1'b0, 1'b0, $urandom_range(0, 500));
			end
			step_ms(1'b0, 1'b1, $urandom_range(0, 500));
			step_ms(1'b0, 1'b0, $urandom_range(0, 500));
			repeat ($urandom_range(3, 14))
				step_ms(1'b0, $urandom_range(0, 19) == 0, $urandom_range(0, span));
			if ($urandom_range(0, 1)) begin
				step_ms(1'b0, 1'b1, $urandom_range(0, 500));
				step_ms(1'b0, 1'b0, $urandom_range(0, 500));
			end
		end else if (kind < 65) begin
			if ($urandom_range(0, 1))
				step_ms(1'b1, 1'b1, $urandom_range(0, 500));
			step_ms(1'b0, 1'b1, $urandom_range(0, 500));
			step_ms(1'b0, 1'b0, $urandom_range(0, 500));
			repeat ($urandom_range(2, 8))
				step_ms(1'b0, 1'b0, $urandom_range(0, 2 * span));
			step_ms(1'b0, 1'b1, $urandom_range(0, 500));
			step_ms(1'b0, 1'b0, $urandom_range(0, 500));
			// from pause: either load more time or resume counting up
			if ($urandom_range(0, 1))
				step_ms(1'b1, 1'b0, $urandom_range(0, 500));
			else
				step_ms(1'b0, 1'b1, $urandom_range(0, 500));
			step_ms(1'b0, 1'b0, $urandom_range(0, span));
		end else if (kind < 90) begin
			repeat ($urandom_range(2, 8)) begin
				if ($urandom_range(0, 3) == 0)
					wall_ms = $urandom();
				step_ms(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					$urandom_range(0, span));
			end
		end else begin
			step_ms(1'b1, 1'b1, $urandom_range(0, 500));
			step_ms(1'b0, 1'b0, $urandom_range(0, 500));
		end
	endtask

	task automatic run_random(input int n, input logic with_hold);
		int  target;
		int  halfway;
		logic paused;
		target  = polls_taken + n;
		halfway = polls_taken + n / 2;
		paused  = 1'b0;
		while (polls_taken < target) begin
			if (!paused && polls_taken >= halfway) begin
				paused = 1'b1;
				drain();
				if (with_hold)
					hold_req = 1'b1;
			end
			random_scenario();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_STEP;
		cfg_data      = '0;
		in_valid      = 1'b0;
		button_set    = 1'b0;
		button_start  = 1'b0;
		now_ms        = '0;
		hold_req      = 1'b0;
		send_gap_pct  = 36;
		recv_gap_pct  = 54;
		wall_ms       = '0;
		cur_step      = STEP_RESET;
		settings_done = 1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset setting: load, count down past zero into the alarm, clear, count up across the wrap
		offer_poll(1'b1, 1'b0, 32'd0);
		offer_poll(1'b0, 1'b0, 32'd0);
		offer_poll(1'b0, 1'b1, 32'd1000);
		offer_poll(1'b0, 1'b0, 32'd30999);
		offer_poll(1'b0, 1'b0, 32'd75000);
		offer_poll(1'b0, 1'b1, 32'd76000);
		offer_poll(1'b0, 1'b0, 32'd76000);
		offer_poll(1'b0, 1'b1, 32'hFFFF_F000);
		offer_poll(1'b0, 1'b0, 32'h0000_1000);
		offer_poll(1'b0, 1'b1, 32'h0000_1000);
		offer_poll(1'b0, 1'b0, 32'h0000_2000);
		offer_poll(1'b0, 1'b1, 32'h0000_3000);
		offer_poll(1'b1, 1'b1, 32'h0000_4000);
		offer_poll(1'b0, 1'b0, 32'h0000_4000);
		wall_ms = 32'h0000_4000;
		run_random(PHASE_POLLS, 1'b0);

		// widest step and limit: saturate the set sum, wrap at the limit, saturate count-up
		apply_setting(4095, 65535);
		offer_poll(1'b1, 1'b1, 32'd0);
		offer_poll(1'b0, 1'b1, 32'd5000);
		offer_poll(1'b0, 1'b0, 32'd65_005_000);
		offer_poll(1'b0, 1'b1, 32'd65_005_000);
		offer_poll(1'b0, 1'b0, 32'd65_005_000);
		offer_poll(1'b1, 1'b0, 32'd65_005_000);
		offer_poll(1'b0, 1'b0, 32'd65_005_000);
		offer_poll(1'b1, 1'b0, 32'd65_005_000);
		offer_poll(1'b0, 1'b0, 32'd65_005_000);
		offer_poll(1'b1, 1'b1, 32'd65_005_000);
		offer_poll(1'b0, 1'b1, 32'd0);
		offer_poll(1'b0, 1'b0, 32'd200_000_000);
		offer_poll(1'b1, 1'b1, 32'd200_000_000);
		wall_ms = 32'd200_000_000;
		run_random(PHASE_POLLS, 1'b1);

		send_gap_pct = 54;
		recv_gap_pct = 36;
		apply_setting(0, 0);
		run_random(PHASE_POLLS, 1'b0);
		apply_setting(1, 1);
		run_random(PHASE_POLLS, 1'b0);

		send_gap_pct = 0;
		recv_gap_pct = 0;
		apply_setting(3600, 7200);
		run_random(PHASE_POLLS, 1'b0);
		apply_setting($urandom_range(1, 3600), $urandom_range(1, 65535));
		run_random(PHASE_POLLS, 1'b0);

		drain();
		$display("covered %0d polls over %0d register settings, modes reached %b (alarm..idle)",
			polls_taken, settings_done, modes_seen[5:0]);
		if (failures == 0 && awaiting == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
